[rtl/core/sbct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared constants and types for the segment / box clearance test.
// ----------------------------------------------------------------------------
package sbct_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int OUT_TDATA_W    = 8;

	// per-item decisions and sign information carried alongside the operands
	typedef struct packed {
		logic bbox_clear;   // bounding boxes do not overlap
		logic end_inside;   // an endpoint lies in the closed rectangle
		logic x1_in;        // low-x edge lies within the segment's x span
		logic x2_in;        // high-x edge lies within the segment's x span
		logic z1_in;        // low-z edge lies within the segment's z span
		logic dx_neg;
		logic dx_zero;
		logic dz_neg;
		logic dz_zero;
	} sbct_flags_t;

endpackage

[rtl/core/sbct_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_prep
// Orders corners, extracts spans, runs the box and endpoint tests and forms
// the multiplier operands for the x1, x2 and z1 edge crossing tests.
// ----------------------------------------------------------------------------
module sbct_prep #(
	parameter int COORD_BITS = sbct_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] seg_ax,
	input  logic signed [COORD_BITS-1:0] seg_az,
	input  logic signed [COORD_BITS-1:0] seg_bx,
	input  logic signed [COORD_BITS-1:0] seg_bz,
	input  logic signed [COORD_BITS-1:0] box_ax,
	input  logic signed [COORD_BITS-1:0] box_az,
	input  logic signed [COORD_BITS-1:0] box_bx,
	input  logic signed [COORD_BITS-1:0] box_bz,
	output sbct_pkg::sbct_flags_t        flags,
	output logic signed [COORD_BITS:0]   dx,
	output logic signed [COORD_BITS:0]   dz,
	output logic signed [COORD_BITS:0]   x1_off,
	output logic signed [COORD_BITS:0]   x2_off,
	output logic signed [COORD_BITS:0]   zlo_off,
	output logic signed [COORD_BITS:0]   zhi_off,
	output logic signed [COORD_BITS:0]   z1_off,
	output logic signed [COORD_BITS:0]   xlo_off,
	output logic signed [COORD_BITS:0]   xhi_off
);

	logic signed [COORD_BITS-1:0] xpl, xph, zpl, zph;
	logic signed [COORD_BITS-1:0] x1, x2, z1, z2;
	logic signed [COORD_BITS-1:0] zlo, zhi, xlo, xhi;
	logic a_in, b_in;

	// widen by one bit so differences never wrap
	function automatic logic signed [COORD_BITS:0] sdiff(
		input logic signed [COORD_BITS-1:0] p,
		input logic signed [COORD_BITS-1:0] q
	);
		logic signed [COORD_BITS:0] pw, qw;
		pw = {p[COORD_BITS-1], p};
		qw = {q[COORD_BITS-1], q};
		return pw - qw;
	endfunction

	always_comb begin
		xpl = (seg_ax < seg_bx) ? seg_ax : seg_bx;
		xph = (seg_ax > seg_bx) ? seg_ax : seg_bx;
		zpl = (seg_az < seg_bz) ? seg_az : seg_bz;
		zph = (seg_az > seg_bz) ? seg_az : seg_bz;
		x1  = (box_ax < box_bx) ? box_ax : box_bx;
		x2  = (box_ax > box_bx) ? box_ax : box_bx;
		z1  = (box_az < box_bz) ? box_az : box_bz;
		z2  = (box_az > box_bz) ? box_az : box_bz;

		// overlap of segment span and rectangle span on each axis
		zlo = (z1 > zpl) ? z1 : zpl;
		zhi = (z2 < zph) ? z2 : zph;
		xlo = (x1 > xpl) ? x1 : xpl;
		xhi = (x2 < xph) ? x2 : xph;

		a_in = (seg_ax >= x1) && (seg_ax <= x2) && (seg_az >= z1) && (seg_az <= z2);
		b_in = (seg_bx >= x1) && (seg_bx <= x2) && (seg_bz >= z1) && (seg_bz <= z2);

		dx = sdiff(seg_bx, seg_ax);
		dz = sdiff(seg_bz, seg_az);

		x1_off  = sdiff(x1, seg_ax);
		x2_off  = sdiff(x2, seg_ax);
		zlo_off = sdiff(zlo, seg_az);
		zhi_off = sdiff(zhi, seg_az);
		z1_off  = sdiff(z1, seg_az);
		xlo_off = sdiff(xlo, seg_ax);
		xhi_off = sdiff(xhi, seg_ax);

		flags.bbox_clear = (xpl > x2) || (xph < x1) || (zpl > z2) || (zph < z1);
		flags.end_inside = a_in || b_in;
		flags.x1_in      = (x1 >= xpl) && (x1 <= xph);
		flags.x2_in      = (x2 >= xpl) && (x2 <= xph);
		flags.z1_in      = (z1 >= zpl) && (z1 <= zph);
		flags.dx_neg     = dx[COORD_BITS];
		flags.dx_zero    = (dx == '0);
		flags.dz_neg     = dz[COORD_BITS];
		flags.dz_zero    = (dz == '0);
	end

endmodule

[rtl/core/sbct_span_hit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_span_hit
// Cross-multiplied window test for one edge: the crossing product must lie
// between the two bound products, with the order set by the run's sign; a zero run never hits.
// ----------------------------------------------------------------------------
module sbct_span_hit #(
	parameter int PROD_BITS = 2 * sbct_pkg::COORD_BITS_DEF + 2
) (
	input  logic signed [PROD_BITS-1:0] cross_p,
	input  logic signed [PROD_BITS-1:0] lo_p,
	input  logic signed [PROD_BITS-1:0] hi_p,
	input  logic                        run_neg,
	input  logic                        run_zero,
	output logic                        hit
);

	logic ge_lo, le_lo, ge_hi, le_hi;

	always_comb begin
		ge_lo = (cross_p >= lo_p);
		le_lo = (cross_p <= lo_p);
		ge_hi = (cross_p >= hi_p);
		le_hi = (cross_p <= hi_p);
		// a negative run flips both bound products
		if (run_zero) begin
			hit = 1'b0;
		end else if (run_neg) begin
			hit = ge_hi && le_lo;
		end else begin
			hit = ge_lo && le_hi;
		end
	end

endmodule

[rtl/core/segment_box_clear_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_clear_test
// Segment versus axis-aligned rectangle clearance test, exact integer math.
// ----------------------------------------------------------------------------
// Pipeline: input register, operand stage, product stage, result register.
// Throughput: one item per cycle; the whole pipe holds while the result waits.
// The seven products are each one (COORD_BITS+1)-bit signed multiplier.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module segment_box_clear_test #(
	parameter  int COORD_BITS = sbct_pkg::COORD_BITS_DEF,
	localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// seg_ax, seg_az, seg_bx, seg_bz, box_ax, box_az, box_bx, box_bz
	input  logic [IN_W-1:0]                 s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// is_clear, zero fill
	output logic [sbct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int OPW  = COORD_BITS + 1;
	localparam int PRDW = 2 * OPW;

	logic en;

	logic                         vld_s1, vld_s2, vld_s3, out_vld_q;
	logic signed [COORD_BITS-1:0] crd_s1 [8];

	sbct_pkg::sbct_flags_t flg_c, flg_s2, flg_s3;
	logic signed [OPW-1:0] dx_c, dz_c, x1o_c, x2o_c, zlo_c, zhi_c, z1o_c, xlo_c, xhi_c;
	logic signed [OPW-1:0] dx_s2, dz_s2, x1o_s2, x2o_s2, zlo_s2, zhi_s2;
	logic signed [OPW-1:0] z1o_s2, xlo_s2, xhi_s2;

	logic signed [PRDW-1:0] qx1_s3, qx2_s3, lx_s3, hx_s3, qz1_s3, lz_s3, hz_s3;
	logic hit_x1, hit_x2, hit_z1, clear_c, is_clear_q;

	// the whole pipe moves together whenever the result slot can take an item
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				crd_s1[i] <= s_axis_tdata[i*COORD_BITS +: COORD_BITS];
			end
		end
	end

	sbct_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.seg_ax (crd_s1[0]),
		.seg_az (crd_s1[1]),
		.seg_bx (crd_s1[2]),
		.seg_bz (crd_s1[3]),
		.box_ax (crd_s1[4]),
		.box_az (crd_s1[5]),
		.box_bx (crd_s1[6]),
		.box_bz (crd_s1[7]),
		.flags  (flg_c),
		.dx     (dx_c),
		.dz     (dz_c),
		.x1_off (x1o_c),
		.x2_off (x2o_c),
		.zlo_off(zlo_c),
		.zhi_off(zhi_c),
		.z1_off (z1o_c),
		.xlo_off(xlo_c),
		.xhi_off(xhi_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s2 <= flg_c;
			dx_s2  <= dx_c;
			dz_s2  <= dz_c;
			x1o_s2 <= x1o_c;
			x2o_s2 <= x2o_c;
			zlo_s2 <= zlo_c;
			zhi_s2 <= zhi_c;
			z1o_s2 <= z1o_c;
			xlo_s2 <= xlo_c;
			xhi_s2 <= xhi_c;
		end
	end

	// left/right edges share their bound products
	always_ff @(posedge clk) begin
		if (en) begin
			flg_s3 <= flg_s2;
			qx1_s3 <= dz_s2 * x1o_s2;
			qx2_s3 <= dz_s2 * x2o_s2;
			lx_s3  <= zlo_s2 * dx_s2;
			hx_s3  <= zhi_s2 * dx_s2;
			qz1_s3 <= dx_s2 * z1o_s2;
			lz_s3  <= xlo_s2 * dz_s2;
			hz_s3  <= xhi_s2 * dz_s2;
		end
	end

	sbct_span_hit #(.PROD_BITS(PRDW)) u_hit_x1 (
		.cross_p (qx1_s3),
		.lo_p    (lx_s3),
		.hi_p    (hx_s3),
		.run_neg (flg_s3.dx_neg),
		.run_zero(flg_s3.dx_zero),
		.hit     (hit_x1)
	);

	sbct_span_hit #(.PROD_BITS(PRDW)) u_hit_x2 (
		.cross_p (qx2_s3),
		.lo_p    (lx_s3),
		.hi_p    (hx_s3),
		.run_neg (flg_s3.dx_neg),
		.run_zero(flg_s3.dx_zero),
		.hit     (hit_x2)
	);

	sbct_span_hit #(.PROD_BITS(PRDW)) u_hit_z1 (
		.cross_p (qz1_s3),
		.lo_p    (lz_s3),
		.hi_p    (hz_s3),
		.run_neg (flg_s3.dz_neg),
		.run_zero(flg_s3.dz_zero),
		.hit     (hit_z1)
	);

	always_comb begin
		clear_c = flg_s3.bbox_clear ||
			(!flg_s3.end_inside &&
			 !(flg_s3.x1_in && hit_x1) &&
			 !(flg_s3.x2_in && hit_x2) &&
			 !(flg_s3.z1_in && hit_z1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_clear_q <= clear_c;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(sbct_pkg::OUT_TDATA_W-1){1'b0}}, is_clear_q};

endmodule

[rtl/core/sbct_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_checker
// Port-level checks on the clearance test's stream behavior.
// ----------------------------------------------------------------------------
module sbct_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [sbct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input side opens exactly when the result slot frees up
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output slot");

	// a new result only appears after the pipe advanced
	a_rise_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tready))
		else $error("result appeared without pipe advance");

	// fill bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[sbct_pkg::OUT_TDATA_W-1:1] == '0))
		else $error("nonzero fill bits in result");

endmodule

bind segment_box_clear_test sbct_checker u_sbct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

[bench/segment_box_clear_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_clear_test_tb
// Streams segment / rectangle queries into segment_box_clear_test and checks
// every is_clear answer against a table entry or an exact integer predictor.
// A directed table of corner cases is followed by random queries, most of
// them clustered around rectangles. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module segment_box_clear_test_tb;

	localparam int CW           = sbct_pkg::COORD_BITS_DEF;
	localparam int IN_W         = ((8 * CW + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_CYCLES = 12;
	localparam int PREDICT      = -1;
	localparam int DIR_ROWS     = 24;

	// high field first so that seg_ax sits in the low bits of tdata
	typedef struct packed {
		logic signed [CW-1:0] box_bz, box_bx, box_az, box_ax;
		logic signed [CW-1:0] seg_bz, seg_bx, seg_az, seg_ax;
	} seg_query_t;

	// seg_ax, seg_az, seg_bx, seg_bz, box_ax, box_az, box_bx, box_bz, is_clear
	int corner_cases [DIR_ROWS][9] = '{
		'{0, 0, 10, 10, 100, 100, 200, 200, 1},
		'{150, 150, 500, 500, 100, 100, 200, 200, 0},
		'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0},
		'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0},
		'{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 0},
		'{-32768, 32767, 32767, -32768, -1, -1, 1, 1, PREDICT},
		'{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 0},
		'{150, 150, 150, 150, 200, 200, 100, 100, 0},
		'{50, 50, 50, 50, 100, 100, 200, 200, 1},
		'{0, 150, 300, 150, 100, 100, 200, 200, PREDICT},
		'{150, 0, 150, 300, 100, 100, 200, 200, PREDICT},
		'{0, 200, 300, 200, 100, 100, 200, 200, PREDICT},
		'{150, 300, 150, 201, 100, 100, 200, 200, 1},
		'{0, 100, 100, 0, 100, 100, 200, 200, PREDICT},
		'{0, 200, 200, 0, 100, 100, 200, 200, PREDICT},
		'{0, 0, 200, 200, 100, 100, 100, 100, PREDICT},
		'{50, 50, 50, 150, 0, 100, 100, 100, PREDICT},
		'{0, 150, 300, 150, 100, 100, 100, 200, PREDICT},
		'{0, 150, 0, 150, 100, 100, 200, 200, 1},
		'{150, 300, 300, 150, 100, 100, 200, 200, PREDICT},
		'{60, 120, 120, 60, 0, 0, 100, 100, PREDICT},
		'{-32768, 0, 32767, 0, -1, -1, 1, 1, PREDICT},
		'{0, -32768, 0, 32767, -1, -1, 1, 1, PREDICT},
		'{-100, -50, -300, -250, -400, -200, -250, -100, PREDICT}
	};

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// seg_ax, seg_az, seg_bx, seg_bz, box_ax, box_az, box_bx, box_bz
	logic [IN_W-1:0]        s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// is_clear, zero fill
	logic [sbct_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	bit          clear_expect_q [$];
	int          mismatch_count = 0;
	bit          calm_send      = 1'b0;
	bit          calm_recv      = 1'b0;
	int          stall_left     = 0;
	int unsigned sink_cycles    = 0;

	segment_box_clear_test uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// does the line through (u0,v0) along (du,dv) hit u = c with v in [lo,hi]?
	function automatic bit crosses_at(longint c, longint u0, longint v0, longint du,
			longint dv, longint lo, longint hi);
		longint p;
		if (du == 0)
			return 1'b0;
		if (du < 0) begin
			du = -du;
			dv = -dv;
		end
		p = dv * (c - u0);
		return (p >= (lo - v0) * du) && (p <= (hi - v0) * du);
	endfunction

	function automatic bit seg_misses_box(seg_query_t q);
		longint ax, az, bx, bz, x1, x2, z1, z2, xlo, xhi, zlo, zhi, dx, dz;
		ax  = q.seg_ax;
		az  = q.seg_az;
		bx  = q.seg_bx;
		bz  = q.seg_bz;
		x1  = (q.box_ax < q.box_bx) ? q.box_ax : q.box_bx;
		x2  = (q.box_ax < q.box_bx) ? q.box_bx : q.box_ax;
		z1  = (q.box_az < q.box_bz) ? q.box_az : q.box_bz;
		z2  = (q.box_az < q.box_bz) ? q.box_bz : q.box_az;
		xlo = (ax < bx) ? ax : bx;
		xhi = (ax < bx) ? bx : ax;
		zlo = (az < bz) ? az : bz;
		zhi = (az < bz) ? bz : az;
		dx  = bx - ax;
		dz  = bz - az;
		if (xlo > x2 || xhi < x1 || zlo > z2 || zhi < z1)
			return 1'b1;
		if ((ax >= x1 && ax <= x2 && az >= z1 && az <= z2) ||
				(bx >= x1 && bx <= x2 && bz >= z1 && bz <= z2))
			return 1'b0;
		// the clipped span of the other axis is shared by the x1 and x2 edges
		if (x1 >= xlo && x1 <= xhi && crosses_at(x1, ax, az, dx, dz,
				(z1 > zlo) ? z1 : zlo, (z2 < zhi) ? z2 : zhi))
			return 1'b0;
		if (x2 >= xlo && x2 <= xhi && crosses_at(x2, ax, az, dx, dz,
				(z1 > zlo) ? z1 : zlo, (z2 < zhi) ? z2 : zhi))
			return 1'b0;
		// high-z edge is not tested by the block
		if (z1 >= zlo && z1 <= zhi && crosses_at(z1, az, ax, dz, dx,
				(x1 > xlo) ? x1 : xlo, (x2 < xhi) ? x2 : xhi))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int spread(int c, int r);
		return c + int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic seg_query_t random_query();
		seg_query_t q;
		int kind, cx, cz, span, hx, hz;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			q = {$urandom, $urandom, $urandom, $urandom};
			return q;
		end
		// cluster segment and rectangle so that most bounding boxes overlap
		span = ($urandom_range(0, 9) == 0) ? 4000 : 400;
		cx   = spread(0, 20000);
		cz   = spread(0, 20000);
		hx   = $urandom_range(0, span / 2);
		hz   = $urandom_range(0, span / 2);
		if (kind < 30)
			hx = 0;
		else if (kind < 36)
			hz = 0;
		if ($urandom_range(0, 1)) begin
			q.box_ax = CW'(cx - hx);
			q.box_bx = CW'(cx + hx);
		end else begin
			q.box_ax = CW'(cx + hx);
			q.box_bx = CW'(cx - hx);
		end
		if ($urandom_range(0, 1)) begin
			q.box_az = CW'(cz - hz);
			q.box_bz = CW'(cz + hz);
		end else begin
			q.box_az = CW'(cz + hz);
			q.box_bz = CW'(cz - hz);
		end
		q.seg_ax = CW'(spread(cx, span));
		q.seg_az = CW'(spread(cz, span));
		q.seg_bx = CW'(spread(cx, span));
		q.seg_bz = CW'(spread(cz, span));
		if (kind >= 40 && kind < 52)
			q.seg_bx = q.seg_ax;
		else if (kind >= 52 && kind < 64)
			q.seg_bz = q.seg_az;
		else if (kind >= 64 && kind < 70) begin
			q.seg_bx = q.seg_ax;
			q.seg_bz = q.seg_az;
		end
		return q;
	endfunction

	// queue the expectation on acceptance; want < 0 takes the predictor's answer
	task automatic send_query(input seg_query_t q, input int want);
		int gap;
		bit exp_clear;
		s_axis_tdata  <= q;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		exp_clear      = (want < 0) ? seg_misses_box(q) : want[0];
		clear_expect_q = {clear_expect_q, exp_clear};
		gap = calm_send ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (clear_expect_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		seg_query_t q;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++) begin
			q.seg_ax = CW'(corner_cases[i][0]);
			q.seg_az = CW'(corner_cases[i][1]);
			q.seg_bx = CW'(corner_cases[i][2]);
			q.seg_bz = CW'(corner_cases[i][3]);
			q.box_ax = CW'(corner_cases[i][4]);
			q.box_az = CW'(corner_cases[i][5]);
			q.box_bx = CW'(corner_cases[i][6]);
			q.box_bz = CW'(corner_cases[i][7]);
			send_query(q, corner_cases[i][8]);
		end
		wait_all_results();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				calm_send = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				wait_all_results();
			send_query(random_query(), PREDICT);
		end
		s_axis_tvalid <= 1'b0;
		while (clear_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && clear_expect_q.size() == 0)
			$display("PASS segment_box_clear_test");
		else
			$display("FAIL segment_box_clear_test");
		$finish;
	end

	always @(posedge clk) begin : sink_pacing
		sink_cycles <= sink_cycles + 1;
		if (sink_cycles % 256 == 0)
			calm_recv <= ($urandom_range(0, 3) == 0);
		if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm_recv && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin : result_check
		bit want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (clear_expect_q.size() == 0) begin
				$error("is_clear: unexpected item, expected none, actual %0d",
					m_axis_tdata[0]);
				mismatch_count++;
			end else begin
				want = clear_expect_q.pop_front();
				if (m_axis_tdata[0] !== want) begin
					$error("is_clear mismatch: expected %0d, actual %0d", want,
						m_axis_tdata[0]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAIL segment_box_clear_test");
		$finish;
	end

endmodule

[sim.f]
rtl/core/sbct_pkg.sv
rtl/core/sbct_prep.sv
rtl/core/sbct_span_hit.sv
rtl/core/segment_box_clear_test.sv
rtl/core/sbct_checker.sv
bench/segment_box_clear_test_tb.sv
